@@ design/pftq_pkg.sv @@
// ============================================================================
// pftq_pkg - shared types and codes for the priority fragment transmit queue
// Action codes, admit status codes and fixed field widths.
// ============================================================================
`default_nettype none

package pftq_pkg;

  // Fixed field widths
  localparam int ACT_W   = 3;
  localparam int STAT_W  = 2;
  localparam int STG_W   = 3;
  localparam int STG_DEPTH = 8;
  localparam int CNT_W   = 4;
  localparam int QCNT_W  = 3;

  typedef logic [ACT_W-1:0]  action_t;
  typedef logic [STAT_W-1:0] status_t;
  typedef logic [CNT_W-1:0]  fcount_t;

  // Actions
  localparam action_t ACT_STAGE   = 3'd0;
  localparam action_t ACT_ADMIT   = 3'd1;
  localparam action_t ACT_PEEK    = 3'd2;
  localparam action_t ACT_ADVANCE = 3'd3;
  localparam action_t ACT_CLEAR   = 3'd4;

  // Admit status
  localparam status_t ST_ACCEPT = 2'd0;
  localparam status_t ST_EVICT  = 2'd1;
  localparam status_t ST_FULL   = 2'd2;
  localparam status_t ST_NONE   = 2'd3;

endpackage : pftq_pkg

`default_nettype wire

@@ design/priority_fragment_tx_queue.sv @@
// ============================================================================
// priority_fragment_tx_queue - transmit queue of fragment message slots
// Staging buffer, slot store, alert-first oldest-first service order.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready) carries one action per transaction:
//   stage a fragment, admit a message, peek, advance or clear. Every action
//   returns exactly one transaction on the output channel (out_valid/
//   out_ready) with the admit status and a snapshot of the queue afterward.
//   Sequencing: the block takes one transaction at a time. A non-admit
//   action is applied at the accepting edge; the shared age comparator then
//   walks every slot in turn to find the head message, followed by one slot
//   store read and one output load. An admit that claims a slot first copies
//   its staged words through the single staging read port into the slot
//   store. in_ready rises again once the result is loaded, so a new
//   transaction is not taken while the last one is still in progress.
//   The result sits in an output register; when the receiver stalls the
//   sequencer holds in its final step until the register is free, and
//   in_ready stays low until the result is loaded.
//   Reset empties all slots and sets the sequence number to one; staged and
//   slot fragment words are not cleared.
// ============================================================================
`default_nettype none

module priority_fragment_tx_queue
  import pftq_pkg::*;
#(
  parameter int NUM_SLOTS = 4,
  parameter int MAX_FRAGS = 8,
  parameter int FRAG_BITS = 64,
  parameter int SEQ_BITS  = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,

  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [ACT_W-1:0]     in_action,
  input  wire logic [STG_W-1:0]     in_frag_index,
  input  wire logic [FRAG_BITS-1:0] in_frag_data,
  input  wire logic [CNT_W-1:0]     in_frag_count,
  input  wire logic                 in_is_alert,

  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [STAT_W-1:0]         out_admit_status,
  output logic [FRAG_BITS-1:0]      out_head_fragment,
  output logic                      out_head_valid,
  output logic                      out_queue_empty,
  output logic                      out_alert_pending,
  output logic [QCNT_W-1:0]         out_queued_count,
  output logic                      out_in_flight
);

  localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int FIDX_W  = (MAX_FRAGS > 1) ? $clog2(MAX_FRAGS) : 1;
  localparam int ADDR_W  = SLOT_W + FIDX_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;
  localparam int BCNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int KEY_W   = SEQ_BITS + 1;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_COPY  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FETCH = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_r, state_nxt;

  // Slot control state
  logic [NUM_SLOTS-1:0] slot_busy_r;
  logic [NUM_SLOTS-1:0] slot_alert_r;
  fcount_t              slot_next_r  [NUM_SLOTS];
  fcount_t              slot_total_r [NUM_SLOTS];
  logic [SEQ_BITS-1:0]  slot_age_r   [NUM_SLOTS];
  logic [SEQ_BITS-1:0]  next_seq_r;

  // Fragment stores
  logic [FRAG_BITS-1:0] stg_mem  [STG_DEPTH];
  logic [FRAG_BITS-1:0] slot_mem [MEM_DEPTH];
  logic [FRAG_BITS-1:0] stg_rd_r;
  logic [FRAG_BITS-1:0] slot_rd_r;

  // Per-transaction working registers
  status_t            status_r;
  fcount_t            cnt_req_r;
  logic               alert_req_r;
  logic [SLOT_W-1:0]  target_r;
  fcount_t            cp_r;

  // Scan accumulators
  logic [SLOT_W-1:0]  sc_r;
  logic [SLOT_W-1:0]  best_r;
  logic               best_vld_r;
  logic [KEY_W-1:0]   best_key_r;
  logic [BCNT_W-1:0]  bcnt_r;
  logic               any_alert_r;
  logic               any_flight_r;

  // Output register
  logic                 out_valid_r;
  status_t              out_status_r;
  logic [FRAG_BITS-1:0] out_frag_r;
  logic                 out_hvld_r;
  logic                 out_empty_r;
  logic                 out_alert_r;
  logic [QCNT_W-1:0]    out_qcnt_r;
  logic                 out_flight_r;

  logic in_fire;
  logic bad_count;
  logic free_found, evict_found;
  logic [SLOT_W-1:0] free_idx, evict_idx;
  logic copy_last;
  logic scan_last;
  logic out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign bad_count = (in_frag_count == '0) || (in_frag_count > CNT_W'(MAX_FRAGS));
  assign copy_last = (cp_r == cnt_req_r);
  assign scan_last = (sc_r == SLOT_W'(NUM_SLOTS - 1));
  assign out_free  = !out_valid_r || out_ready;

  // Find the lowest free slot and the lowest evictable normal slot
  always_comb begin
    free_found  = 1'b0;
    evict_found = 1'b0;
    free_idx    = '0;
    evict_idx   = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!free_found && !slot_busy_r[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
      if (!evict_found && slot_busy_r[i] && !slot_alert_r[i] && (slot_next_r[i] == '0)) begin
        evict_found = 1'b1;
        evict_idx   = SLOT_W'(i);
      end
    end
  end

  // Shared comparator step: fold the scanned slot into the running best
  logic [KEY_W-1:0]  sc_key;
  logic [BCNT_W-1:0] base_cnt;
  logic [KEY_W-1:0]  base_key;
  logic              base_vld, base_alert, base_flight;
  logic              sc_take;

  always_comb begin
    sc_key      = {~slot_alert_r[sc_r], slot_age_r[sc_r]};
    base_cnt    = (sc_r == '0) ? '0   : bcnt_r;
    base_vld    = (sc_r == '0) ? 1'b0 : best_vld_r;
    base_alert  = (sc_r == '0) ? 1'b0 : any_alert_r;
    base_flight = (sc_r == '0) ? 1'b0 : any_flight_r;
    base_key    = best_key_r;
    sc_take     = slot_busy_r[sc_r] && (!base_vld || (sc_key < base_key));
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if ((in_action == ACT_ADMIT) && !bad_count &&
              (free_found || (in_is_alert && evict_found))) begin
            state_nxt = S_COPY;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_COPY: begin
        if (copy_last) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (scan_last) state_nxt = S_FETCH;
      end
      S_FETCH: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // Slot control state and sequencer working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_busy_r  <= '0;
      slot_alert_r <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_next_r[i]  <= '0;
        slot_total_r[i] <= '0;
        slot_age_r[i]   <= '0;
      end
      next_seq_r <= SEQ_BITS'(1);
      best_vld_r <= 1'b0;
      best_r     <= '0;
      sc_r       <= '0;
      cp_r       <= '0;
      status_r   <= ST_NONE;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            sc_r        <= '0;
            cp_r        <= '0;
            cnt_req_r   <= in_frag_count;
            alert_req_r <= in_is_alert;
            case (in_action)
              ACT_ADMIT: begin
                if (bad_count) begin
                  status_r <= ST_FULL;
                end else if (free_found) begin
                  status_r <= ST_ACCEPT;
                  target_r <= free_idx;
                end else if (in_is_alert && evict_found) begin
                  status_r <= ST_EVICT;
                  target_r <= evict_idx;
                end else begin
                  status_r <= ST_FULL;
                end
              end
              ACT_ADVANCE: begin
                status_r <= ST_NONE;
                // step the head message; free the slot after its last fragment
                if (best_vld_r) begin
                  if ((slot_next_r[best_r] + 4'd1) >= slot_total_r[best_r]) begin
                    slot_busy_r[best_r]  <= 1'b0;
                    slot_next_r[best_r]  <= '0;
                    slot_total_r[best_r] <= '0;
                  end else begin
                    slot_next_r[best_r] <= slot_next_r[best_r] + 4'd1;
                  end
                end
              end
              ACT_CLEAR: begin
                status_r     <= ST_NONE;
                slot_busy_r  <= '0;
                slot_alert_r <= '0;
                for (int i = 0; i < NUM_SLOTS; i++) begin
                  slot_next_r[i]  <= '0;
                  slot_total_r[i] <= '0;
                  slot_age_r[i]   <= '0;
                end
                next_seq_r <= SEQ_BITS'(1);
              end
              default: status_r <= ST_NONE;
            endcase
          end
        end
        S_COPY: begin
          // commit the slot once the last word is written
          if (copy_last) begin
            slot_busy_r[target_r]  <= 1'b1;
            slot_alert_r[target_r] <= alert_req_r;
            slot_next_r[target_r]  <= '0;
            slot_total_r[target_r] <= cnt_req_r;
            slot_age_r[target_r]   <= next_seq_r;
            next_seq_r             <= next_seq_r + SEQ_BITS'(1);
          end else begin
            cp_r <= cp_r + 4'd1;
          end
        end
        S_SCAN: begin
          bcnt_r       <= base_cnt + BCNT_W'(slot_busy_r[sc_r]);
          any_alert_r  <= base_alert  || (slot_busy_r[sc_r] && slot_alert_r[sc_r]);
          any_flight_r <= base_flight || (slot_busy_r[sc_r] && (slot_next_r[sc_r] != '0));
          best_vld_r   <= base_vld || slot_busy_r[sc_r];
          if (sc_take) begin
            best_r     <= sc_r;
            best_key_r <= sc_key;
          end
          if (!scan_last) sc_r <= sc_r + SLOT_W'(1);
        end
        default: ;
      endcase
    end
  end

  // Staging store: write on stage, read one word per copy cycle
  always_ff @(posedge clk) begin
    if (in_fire && (in_action == ACT_STAGE)) begin
      stg_mem[in_frag_index] <= in_frag_data;
    end
    if (state_r == S_COPY) begin
      stg_rd_r <= stg_mem[STG_W'(cp_r)];
    end
  end

  // Slot store: write the word read in the previous copy cycle, read the head
  always_ff @(posedge clk) begin
    if ((state_r == S_COPY) && (cp_r != '0)) begin
      slot_mem[{target_r, FIDX_W'(cp_r - 4'd1)}] <= stg_rd_r;
    end
    if (state_r == S_FETCH) begin
      slot_rd_r <= slot_mem[{best_r, FIDX_W'(slot_next_r[best_r])}];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r  <= 1'b1;
        out_status_r <= status_r;
        out_frag_r   <= best_vld_r ? slot_rd_r : '0;
        out_hvld_r   <= best_vld_r;
        out_empty_r  <= (bcnt_r == '0);
        out_alert_r  <= any_alert_r;
        out_qcnt_r   <= (int'(bcnt_r) > 7) ? 3'd7 : QCNT_W'(bcnt_r);
        out_flight_r <= any_flight_r;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_admit_status  = out_status_r;
  assign out_head_fragment = out_frag_r;
  assign out_head_valid    = out_hvld_r;
  assign out_queue_empty   = out_empty_r;
  assign out_alert_pending = out_alert_r;
  assign out_queued_count  = out_qcnt_r;
  assign out_in_flight     = out_flight_r;

  // Assertions
  a_head_matches_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_head_valid == !out_queue_empty))
    else $error("head_valid disagrees with queue_empty");

  a_alert_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_alert_pending || out_in_flight)) |-> !out_queue_empty)
    else $error("alert or in-flight flag on an empty queue");

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((int'(out_queued_count) <= NUM_SLOTS) &&
                   ((out_queued_count == '0) == out_queue_empty)))
    else $error("queued count out of range");

  a_copy_holds_target: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_COPY) && !copy_last) |=> $stable(target_r) && (state_r == S_COPY))
    else $error("copy target changed mid-copy");

  a_busy_slot_sane: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FETCH) |-> (!slot_busy_r[best_r] ||
      ((slot_next_r[best_r] < slot_total_r[best_r]) &&
       (slot_total_r[best_r] <= CNT_W'(MAX_FRAGS)))))
    else $error("head slot fragment position out of range");

endmodule : priority_fragment_tx_queue

`default_nettype wire
